>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/ckrle_pkg.sv
// ----------------------------------------------------------------------------
// Color-key RLE package
// Widths, limits, register indexes and the command format passed from the
// front end to the write sequencer.
// ----------------------------------------------------------------------------
package ckrle_pkg;

   localparam int MAX_WIDTH = 256;
   localparam int MAX_ROWS  = 1024;
   localparam int MAX_RUN   = 255;

   localparam int PIX_W     = 8;
   localparam int OFF_W     = 9;
   localparam int COL_W     = 9;
   localparam int WIDTH_W   = 9;
   localparam int ROWS_W    = 11;
   localparam int ROW_IDX_W = $clog2(MAX_ROWS);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam int WR_SLOTS  = 5;
   localparam int SLOT_W    = $clog2(WR_SLOTS + 1);
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_COLORKEY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd2;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [PIX_W-1:0] value;
   } write_type;

   typedef struct packed {
      write_type [WR_SLOTS-1:0] wr;
      logic [SLOT_W-1:0]        count;
      logic                     hdr;
      logic [OFF_W-1:0]         row_length;
      logic                     sprite_done;
   } cmd_type;

endpackage

>>> src/ckrle_front.sv
// ----------------------------------------------------------------------------
// Color-key RLE front end
// Holds the configuration and the run state, classifies each pixel and
// builds the list of byte writes that it causes.
// ----------------------------------------------------------------------------
module ckrle_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ckrle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ckrle_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ckrle_pkg::PIX_W-1:0]         req_pixel,
   input  logic                                q_full,
   output logic                                q_push,
   output ckrle_pkg::cmd_type                  q_cmd
);
   import ckrle_pkg::*;

   logic [PIX_W-1:0]     colorkey_ff;
   logic [WIDTH_W-1:0]   row_width_ff;
   logic [ROWS_W-1:0]    row_count_ff;

   logic                 opq_ff, opq_in;
   logic [7:0]           run_ff, run_in;
   logic [7:0]           seg_ff, seg_in;
   logic [OFF_W-1:0]     wo_ff, wo_in;
   logic [OFF_W-1:0]     cs_ff, cs_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic                 accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && (q_cmd.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         colorkey_ff  <= '0;
         row_width_ff <= WIDTH_W'(MAX_WIDTH);
         row_count_ff <= ROWS_W'(64);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COLORKEY:  colorkey_ff  <= csr_wdata[PIX_W-1:0];
            CSR_ROW_WIDTH: row_width_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opq_ff <= 1'b0;
         run_ff <= '0;
         seg_ff <= '0;
         wo_ff  <= OFF_W'(1);
         cs_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         opq_ff <= opq_in;
         run_ff <= run_in;
         seg_ff <= seg_in;
         wo_ff  <= wo_in;
         cs_ff  <= cs_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      logic [SLOT_W-1:0]  k;
      logic               o;
      logic [7:0]         r;
      logic [7:0]         s;
      logic [OFF_W-1:0]   w;
      logic [OFF_W-1:0]   c;
      logic [COL_W-1:0]   col_n;
      logic [WIDTH_W-1:0] width;
      logic [ROWS_W-1:0]  rows;
      logic [ROWS_W-1:0]  ri;
      logic               sd;

      q_cmd = '0;
      k = '0;
      o = opq_ff;
      r = run_ff;
      s = seg_ff;
      w = wo_ff;
      c = cs_ff;

      if (row_width_ff == '0) begin
         width = WIDTH_W'(1);
      end else if (row_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         width = WIDTH_W'(MAX_WIDTH);
      end else begin
         width = row_width_ff;
      end
      if (row_count_ff == '0) begin
         rows = ROWS_W'(1);
      end else if (row_count_ff > ROWS_W'(MAX_ROWS)) begin
         rows = ROWS_W'(MAX_ROWS);
      end else begin
         rows = row_count_ff;
      end

      if (req_pixel == colorkey_ff) begin
         if (o) begin
            q_cmd.wr[k].offset = c;
            q_cmd.wr[k].value  = r;
            k = k + SLOT_W'(1);
            s = s + 8'd1;
            o = 1'b0;
            r = 8'd1;
         end else if (r >= 8'(MAX_RUN)) begin
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = r;
            k = k + SLOT_W'(1);
            q_cmd.wr[k].offset = w + OFF_W'(1);
            q_cmd.wr[k].value  = '0;
            k = k + SLOT_W'(1);
            w = w + OFF_W'(2);
            s = s + 8'd1;
            r = 8'd1;
         end else begin
            r = r + 8'd1;
         end
      end else begin
         if (!o) begin
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = r;
            k = k + SLOT_W'(1);
            c = w + OFF_W'(1);
            w = w + OFF_W'(2);
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = req_pixel;
            k = k + SLOT_W'(1);
            w = w + OFF_W'(1);
            o = 1'b1;
            r = 8'd1;
         end else if (r >= 8'(MAX_RUN)) begin
            q_cmd.wr[k].offset = c;
            q_cmd.wr[k].value  = r;
            k = k + SLOT_W'(1);
            s = s + 8'd1;
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = '0;
            k = k + SLOT_W'(1);
            c = w + OFF_W'(1);
            w = w + OFF_W'(2);
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = req_pixel;
            k = k + SLOT_W'(1);
            w = w + OFF_W'(1);
            r = 8'd1;
         end else begin
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = req_pixel;
            k = k + SLOT_W'(1);
            w = w + OFF_W'(1);
            r = r + 8'd1;
         end
      end

      col_n = col_ff + COL_W'(1);
      ri    = ROWS_W'(row_ff) + ROWS_W'(1);
      sd    = (ri >= rows);
      row_in = row_ff;

      if (col_n >= width) begin
         if (o) begin
            q_cmd.wr[k].offset = c;
            q_cmd.wr[k].value  = r;
            k = k + SLOT_W'(1);
         end else begin
            q_cmd.wr[k].offset = w;
            q_cmd.wr[k].value  = r;
            k = k + SLOT_W'(1);
            q_cmd.wr[k].offset = w + OFF_W'(1);
            q_cmd.wr[k].value  = '0;
            k = k + SLOT_W'(1);
            w = w + OFF_W'(2);
         end
         s = s + 8'd1;
         q_cmd.wr[k].offset = '0;
         q_cmd.wr[k].value  = s;
         k = k + SLOT_W'(1);
         q_cmd.hdr         = 1'b1;
         q_cmd.row_length  = w;
         q_cmd.sprite_done = sd;
         row_in = sd ? '0 : ri[ROW_IDX_W-1:0];
         opq_in = 1'b0;
         run_in = '0;
         seg_in = '0;
         wo_in  = OFF_W'(1);
         cs_in  = '0;
         col_in = '0;
      end else begin
         opq_in = o;
         run_in = r;
         seg_in = s;
         wo_in  = w;
         cs_in  = c;
         col_in = col_n;
      end
      q_cmd.count = k;
   end

endmodule

>>> src/ckrle_queue.sv
// ----------------------------------------------------------------------------
// Color-key RLE command queue
// Short register FIFO that decouples the front end from the write sequencer.
// ----------------------------------------------------------------------------
module ckrle_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ckrle_pkg::cmd_type   push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output ckrle_pkg::cmd_type   head_cmd
);
   import ckrle_pkg::*;

   cmd_type                mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]       count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (Q_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/ckrle_back.sv
// ----------------------------------------------------------------------------
// Color-key RLE write sequencer
// Walks the write list of the command at the queue head, one byte write per
// beat, into the registered result channel.
// ----------------------------------------------------------------------------
module ckrle_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  ckrle_pkg::cmd_type              head_cmd,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ckrle_pkg::OFF_W-1:0]     rsp_byte_offset,
   output logic [ckrle_pkg::PIX_W-1:0]     rsp_byte_value,
   output logic                            rsp_row_done,
   output logic [ckrle_pkg::OFF_W-1:0]     rsp_row_length,
   output logic                            rsp_sprite_done,
   output logic                            rsp_last
);
   import ckrle_pkg::*;

   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]   offset_ff;
   logic [PIX_W-1:0]   value_ff;
   logic               row_done_ff;
   logic [OFF_W-1:0]   row_length_ff;
   logic               sprite_done_ff;
   logic               last_ff;
   logic               load;
   logic               is_last;
   write_type          sel;

   assign sel     = head_cmd.wr[idx_ff];
   assign is_last = (idx_ff == head_cmd.count - SLOT_W'(1));
   assign load    = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? '0 : idx_ff + SLOT_W'(1);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         offset_ff      <= sel.offset;
         value_ff       <= sel.value;
         row_done_ff    <= is_last && head_cmd.hdr;
         row_length_ff  <= (is_last && head_cmd.hdr) ? head_cmd.row_length : '0;
         sprite_done_ff <= is_last && head_cmd.hdr && head_cmd.sprite_done;
         last_ff        <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_byte_value  = value_ff;
   assign rsp_row_done    = row_done_ff;
   assign rsp_row_length  = row_length_ff;
   assign rsp_sprite_done = sprite_done_ff;
   assign rsp_last        = last_ff;

endmodule

>>> src/colorkey_rle_sprite_encoder.sv
// ----------------------------------------------------------------------------
// Color-key run-length sprite encoder
// Codes palette-index pixels, row by row, into transparent/opaque segments
// given as individually addressed byte writes.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel, one palette index per beat, in raster
// order. Each pixel causes zero to five byte writes on the rsp_ channel, each
// with its offset in the encoded row; rsp_last marks the final write of a
// pixel. The row header (segment count at offset 0) comes last in a row with
// rsp_row_done and rsp_row_length; rsp_sprite_done marks the final row.
// The csr_ port writes the color key, row width and row count; the user must
// write them only while idle, which the block itself does not enforce. A
// pixel is accepted every cycle while the four-entry command queue has room.
// The front end classifies a pixel in the cycle it is accepted; the sequencer
// then sustains one write per cycle while rsp_ready is high. The first write
// of a pixel passes through a queue entry and then the output register.
// When rsp_ready is low the output register holds its beat, the queue fills
// and req_ready drops once all four entries are taken.
// Reset clears the run state, starts at row zero and loads color key 0,
// row width 256 and row count 64; it acts synchronously on the clock edge.
// ----------------------------------------------------------------------------
module colorkey_rle_sprite_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ckrle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ckrle_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ckrle_pkg::PIX_W-1:0]         req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ckrle_pkg::OFF_W-1:0]         rsp_byte_offset,
   output logic [ckrle_pkg::PIX_W-1:0]         rsp_byte_value,
   output logic                                rsp_row_done,
   output logic [ckrle_pkg::OFF_W-1:0]         rsp_row_length,
   output logic                                rsp_sprite_done,
   output logic                                rsp_last
);
   import ckrle_pkg::*;

`include "assert_macros.svh"

   logic     q_full;
   logic     q_push;
   cmd_type  q_cmd;
   logic     q_pop;
   logic     head_valid;
   cmd_type  head_cmd;

   ckrle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   ckrle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ckrle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_row_done    (rsp_row_done),
      .rsp_row_length  (rsp_row_length),
      .rsp_sprite_done (rsp_sprite_done),
      .rsp_last        (rsp_last)
   );

   `ASSERT_IMPLIES(a_hdr_shape, clock, reset, rsp_valid && rsp_row_done, (rsp_byte_offset == '0) && rsp_last)
   `ASSERT_IMPLIES(a_sprite_row, clock, reset, rsp_valid && rsp_sprite_done, rsp_row_done)
   `ASSERT_IMPLIES(a_queue_nonempty, clock, reset, head_valid, head_cmd.count != '0)
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color-key RLE sprite encoder testbench
// Streams palette-index pixels into the encoder and checks every byte write
// against an in-bench encoder model. Row width, row count and color key are
// changed between phases, including clamped values and changes mid-row,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import ckrle_pkg::*;

   localparam logic [ckrle_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int ROWS_AT_RESET = 64;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [ckrle_pkg::OFF_W-1:0] offset;
      logic [ckrle_pkg::PIX_W-1:0] value;
      logic                        row_done;
      logic [ckrle_pkg::OFF_W-1:0] row_length;
      logic                        sprite_done;
      logic                        last;
   } encoded_write_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [ckrle_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [ckrle_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [ckrle_pkg::PIX_W-1:0]        req_pixel = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [ckrle_pkg::OFF_W-1:0]        rsp_byte_offset;
   logic [ckrle_pkg::PIX_W-1:0]        rsp_byte_value;
   logic                               rsp_row_done;
   logic [ckrle_pkg::OFF_W-1:0]        rsp_row_length;
   logic                               rsp_sprite_done;
   logic                               rsp_last;

   colorkey_rle_sprite_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_row_done    (rsp_row_done),
      .rsp_row_length  (rsp_row_length),
      .rsp_sprite_done (rsp_sprite_done),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   logic [ckrle_pkg::PIX_W-1:0] pixel_queue [$];
   encoded_write_type           expected_writes [$];
   int                          mismatches = 0;
   int                          cycles = 0;
   logic                        req_taken = 1'b0;
   int                          pixels_sent = 0;
   int                          pixels_taken = 0;

   int burst_left = 0;
   int gap_left = 0;
   bit no_gaps = 1'b0;
   int rsp_mode = 0;
   int stall_left = 0;

   // Encoder model: configuration and per-row coding state.
   logic [7:0]                  key_reg = '0;
   logic [ckrle_pkg::WIDTH_W-1:0] width_reg = WIDTH_W'(MAX_WIDTH);
   logic [ckrle_pkg::ROWS_W-1:0]  rows_reg = ROWS_W'(ROWS_AT_RESET);
   bit                          opaque_phase;
   int                          run_len;
   logic [7:0]                  seg_count;
   logic [ckrle_pkg::OFF_W-1:0] next_offset;
   logic [ckrle_pkg::OFF_W-1:0] count_slot;
   int                          col;
   int                          row_num;
   encoded_write_type           step_buf [0:4];
   int                          step_n;

   task automatic start_row();
      opaque_phase = 1'b0;
      run_len = 0;
      seg_count = '0;
      next_offset = 9'd1;
      count_slot = '0;
      col = 0;
   endtask

   task automatic emit_write(input logic [8:0] off, input logic [7:0] val,
                             input logic done, input logic [8:0] len,
                             input logic sdone);
      step_buf[step_n] = '{off, val, done, len, sdone, 1'b0};
      step_n++;
   endtask

   task automatic close_transparent();
      emit_write(next_offset, run_len[7:0], 1'b0, '0, 1'b0);
      emit_write(next_offset + 9'd1, 8'd0, 1'b0, '0, 1'b0);
      next_offset = next_offset + 9'd2;
      seg_count = seg_count + 8'd1;
   endtask

   task automatic open_opaque(input logic [7:0] trans, input logic [7:0] pix);
      emit_write(next_offset, trans, 1'b0, '0, 1'b0);
      count_slot = next_offset + 9'd1;
      next_offset = next_offset + 9'd2;
      emit_write(next_offset, pix, 1'b0, '0, 1'b0);
      next_offset = next_offset + 9'd1;
   endtask

   task automatic close_opaque();
      emit_write(count_slot, run_len[7:0], 1'b0, '0, 1'b0);
      seg_count = seg_count + 8'd1;
   endtask

   task automatic encode_pixel(input logic [7:0] pix);
      int   width;
      int   rows;
      logic sdone;
      int   i;
      step_n = 0;
      width = width_reg;
      if (width < 1) width = 1;
      if (width > ckrle_pkg::MAX_WIDTH) width = ckrle_pkg::MAX_WIDTH;
      rows = rows_reg;
      if (rows < 1) rows = 1;
      if (rows > ckrle_pkg::MAX_ROWS) rows = ckrle_pkg::MAX_ROWS;
      if (pix == key_reg) begin
         if (opaque_phase) begin
            close_opaque();
            opaque_phase = 1'b0;
            run_len = 1;
         end else if (run_len >= ckrle_pkg::MAX_RUN) begin
            close_transparent();
            run_len = 1;
         end else begin
            run_len++;
         end
      end else begin
         if (!opaque_phase) begin
            open_opaque(run_len[7:0], pix);
            opaque_phase = 1'b1;
            run_len = 1;
         end else if (run_len >= ckrle_pkg::MAX_RUN) begin
            close_opaque();
            open_opaque(8'd0, pix);
            run_len = 1;
         end else begin
            emit_write(next_offset, pix, 1'b0, '0, 1'b0);
            next_offset = next_offset + 9'd1;
            run_len++;
         end
      end
      col++;
      if (col >= width) begin
         if (opaque_phase) close_opaque();
         else close_transparent();
         row_num++;
         sdone = (row_num >= rows);
         emit_write('0, seg_count, 1'b1, next_offset, sdone);
         if (sdone) row_num = 0;
         start_row();
      end
      for (i = 0; i < step_n; i++) begin
         if (i == step_n - 1) step_buf[i].last = 1'b1;
         expected_writes = {expected_writes, step_buf[i]};
      end
   endtask

   always @(posedge clock) begin : scoreboard
      encoded_write_type want;
      encoded_write_type got;
      if (reset) begin
         key_reg = '0;
         width_reg = WIDTH_W'(MAX_WIDTH);
         rows_reg = ROWS_W'(ROWS_AT_RESET);
         start_row();
         row_num = 0;
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_byte_offset, rsp_byte_value, rsp_row_done, rsp_row_length,
                    rsp_sprite_done, rsp_last};
            if (expected_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected write: off=%0d val=%02h done=%0b len=%0d sdone=%0b last=%0b",
                           got.offset, got.value, got.row_done, got.row_length,
                           got.sprite_done, got.last);
            end else begin
               want = expected_writes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected off=%0d val=%02h done=%0b len=%0d sdone=%0b last=%0b",
                              want.offset, want.value, want.row_done, want.row_length,
                              want.sprite_done, want.last);
                     $display("          actual   off=%0d val=%02h done=%0b len=%0d sdone=%0b last=%0b",
                              got.offset, got.value, got.row_done, got.row_length,
                              got.sprite_done, got.last);
                  end
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               ckrle_pkg::CSR_COLORKEY:  key_reg = csr_wdata[7:0];
               ckrle_pkg::CSR_ROW_WIDTH: width_reg = csr_wdata[ckrle_pkg::WIDTH_W-1:0];
               ckrle_pkg::CSR_ROW_COUNT: rows_reg = csr_wdata[ckrle_pkg::ROWS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            encode_pixel(req_pixel);
            pixels_taken++;
         end
         req_taken <= req_valid && req_ready;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = no_gaps ? 0 : $urandom_range(0, 6);
         end
         if (burst_left > 0 && pixel_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_queue.pop_front();
            pixels_sent++;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            if (burst_left == 0 && gap_left > 0) gap_left--;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (rsp_mode == 1 && $urandom_range(0, 99) < 30) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 1);
      end else if (rsp_mode == 2 && $urandom_range(0, 99) < 8) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 19);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [ckrle_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ckrle_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || pixels_sent != pixels_taken ||
             expected_writes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic add_pixel(input logic [7:0] p);
      pixel_queue = {pixel_queue, p};
   endtask

   task automatic queue_pixels(input logic [7:0] p0, input logic [7:0] p1,
                               input logic [7:0] p2);
      add_pixel(p0);
      add_pixel(p1);
      add_pixel(p2);
   endtask

   initial begin : stimulus
      int random_items;
      int n;
      int key_pct;
      int r;
      int i;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a full row of key pixels overflows the transparent run.
      rsp_mode = 0;
      for (i = 0; i < 256; i++) add_pixel(8'h00);
      wait_idle();

      // Width above the limit clamps to 256; a full opaque row overflows the run.
      rsp_mode = 1;
      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd511);
      for (i = 0; i < 256; i++) add_pixel(PIX_W'($urandom_range(1, 255)));
      wait_idle();

      write_reg(ckrle_pkg::CSR_COLORKEY, 11'h3C5);
      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd4);
      write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd2);
      write_reg(CSR_SPARE, 11'h7FF);
      queue_pixels(8'hC5, 8'hFF, 8'h00);
      queue_pixels(8'hC5, 8'h00, 8'hC5);
      add_pixel(8'hC5);
      add_pixel(8'h01);
      wait_idle();

      rsp_mode = 2;
      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd1);
      write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd1);
      queue_pixels(8'hC5, 8'h00, 8'hFF);
      wait_idle();

      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd0);
      write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd0);
      add_pixel(8'h5A);
      add_pixel(8'hC5);
      wait_idle();

      rsp_mode = 0;
      write_reg(ckrle_pkg::CSR_COLORKEY, 11'h000);
      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd3);
      write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd2047);
      queue_pixels(8'h00, 8'h00, 8'h00);
      queue_pixels(8'h80, 8'h7F, 8'h00);
      wait_idle();

      // A narrower width written mid-row ends the row on the next pixel.
      write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd1024);
      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd256);
      queue_pixels(8'h00, 8'h33, 8'hCC);
      add_pixel(8'h00);
      add_pixel(8'h00);
      wait_idle();
      write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd3);
      add_pixel(8'h44);
      add_pixel(8'h00);
      wait_idle();

      random_items = 0;
      while (random_items < 160) begin
         rsp_mode = $urandom_range(0, 2);
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1))
            write_reg(ckrle_pkg::CSR_COLORKEY, CSR_DATA_W'($urandom_range(0, 2047)));
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 9);
            case (r)
               0: write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd0);
               1: write_reg(ckrle_pkg::CSR_ROW_WIDTH, 11'd1);
               2: write_reg(ckrle_pkg::CSR_ROW_WIDTH,
                            CSR_DATA_W'($urandom_range(257, 511)));
               3: write_reg(ckrle_pkg::CSR_ROW_WIDTH,
                            CSR_DATA_W'($urandom_range(20, 64)));
               default: write_reg(ckrle_pkg::CSR_ROW_WIDTH,
                                  CSR_DATA_W'($urandom_range(2, 12)));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 7);
            case (r)
               0: write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd0);
               1: write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd2047);
               2: write_reg(ckrle_pkg::CSR_ROW_COUNT, 11'd1024);
               default: write_reg(ckrle_pkg::CSR_ROW_COUNT,
                                  CSR_DATA_W'($urandom_range(1, 4)));
            endcase
         end
         key_pct = $urandom_range(0, 100);
         n = $urandom_range(5, 30);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < key_pct) add_pixel(key_reg);
            else add_pixel(PIX_W'($urandom_range(0, 255)));
         end
         random_items += n;
         wait_idle();
      end

      if (mismatches == 0 && expected_writes.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
